// ----- hw/rtl/keyed_substitution_cipher_macros.svh -----
// ----------------------------------------------------------------------------
// keyed substitution cipher assertion macros
// Concurrent checks on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef KEYED_SUBSTITUTION_CIPHER_MACROS_SVH
`define KEYED_SUBSTITUTION_CIPHER_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define KSC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define KSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/ksc_pkg.sv -----
// ----------------------------------------------------------------------------
// ksc_pkg
// Shared types, codes and constants of the keyed substitution cipher.
// ----------------------------------------------------------------------------
package ksc_pkg;

  localparam int unsigned KSC_ALPHABET = 26;
  localparam int unsigned LETTER_W     = 5;
  localparam int unsigned ROT_W        = 5;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 5;

  // request codes carried in req_type
  typedef enum logic [2:0] {
    REQ_KEY1     = 3'd0,
    REQ_KEY2     = 3'd1,
    REQ_ENCIPHER = 3'd2,
    REQ_DECIPHER = 3'd3,
    REQ_CLEAR    = 3'd4
  } ksc_req_e;

  // keying modes
  typedef enum logic [1:0] {
    MODE_K1 = 2'd0,
    MODE_K2 = 2'd1,
    MODE_K3 = 2'd2,
    MODE_K4 = 2'd3
  } ksc_mode_e;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KEYING_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_ROTATION = 2'd1;

  // top level control
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REBUILD,
    ST_ISSUE,
    ST_LOOKUP
  } ksc_state_e;

  // map rebuild sequencer
  typedef enum logic [1:0] {
    RB_IDLE,
    RB_GEN,
    RB_MAP,
    RB_FLUSH
  } ksc_rb_state_e;

  // channel payloads
  typedef struct packed {
    logic [2:0]          req_type;
    logic [LETTER_W-1:0] letter_in;
    logic                restart_keyword;
    logic                last_letter;
  } ksc_req_t;

  typedef struct packed {
    logic [LETTER_W-1:0] letter_out;
    logic                last_out;
  } ksc_res_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] wr_data;
  } ksc_cfg_t;

  // keyword store command
  typedef struct packed {
    logic                load;
    logic                restart;
    logic                clear;
    logic [LETTER_W-1:0] letter;
  } ksc_key_cmd_t;

  // map write port: forward[pt] = ct and inverse[ct] = pt
  typedef struct packed {
    logic                en;
    logic [LETTER_W-1:0] pt;
    logic [LETTER_W-1:0] ct;
  } ksc_map_wr_t;

  // rotation value reduced modulo the alphabet size, one entry per value
  typedef logic [2**ROT_W-1:0][LETTER_W-1:0] ksc_mod_tbl_t;

  function automatic ksc_mod_tbl_t ksc_mod_table(int unsigned n);
    ksc_mod_tbl_t        tbl;
    logic [LETTER_W-1:0] m;
    m = '0;
    for (int i = 0; i < 2**ROT_W; i++) begin
      tbl[i] = m;
      if (int'(m) + 1 >= int'(n)) begin
        m = '0;
      end else begin
        m = m + 1'b1;
      end
    end
    return tbl;
  endfunction

endpackage

// ----- hw/rtl/ksc_chan_if.sv -----
// ----------------------------------------------------------------------------
// ksc_chan_if
// Valid/ready channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
interface ksc_chan_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

// ----- hw/rtl/ksc_key_store.sv -----
// ----------------------------------------------------------------------------
// ksc_key_store
// One keyword: letter memory, letter-present mask and length, with a
// registered read port for the map rebuild.
// ----------------------------------------------------------------------------
module ksc_key_store #(
  parameter int unsigned ALPHABET_LETTERS = ksc_pkg::KSC_ALPHABET
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  ksc_pkg::ksc_key_cmd_t                  cmd_i,
  input  logic [$clog2(ALPHABET_LETTERS)-1:0]    rd_addr_i,
  output logic [ALPHABET_LETTERS-1:0]            seen_o,
  output logic [$clog2(ALPHABET_LETTERS+1)-1:0]  len_o,
  output logic [ksc_pkg::LETTER_W-1:0]           rd_data_o
);
  import ksc_pkg::*;

  localparam int unsigned IDX_W = $clog2(ALPHABET_LETTERS);
  localparam int unsigned CNT_W = $clog2(ALPHABET_LETTERS + 1);

  logic [ALPHABET_LETTERS-1:0] seen_q, seen_d, seen_base;
  logic [CNT_W-1:0]            len_q, len_d, len_base;
  logic [IDX_W-1:0]            letter_idx;
  logic                        in_range, fresh, wr_en;
  logic [LETTER_W-1:0]         mem_q [ALPHABET_LETTERS];
  logic [LETTER_W-1:0]         rd_data_q;

  // restart empties the keyword before the letter is added
  always_comb begin
    seen_base  = cmd_i.restart ? '0 : seen_q;
    len_base   = cmd_i.restart ? '0 : len_q;
    in_range   = (LETTER_W+1)'(cmd_i.letter) < (LETTER_W+1)'(ALPHABET_LETTERS);
    letter_idx = cmd_i.letter[IDX_W-1:0];
    fresh      = in_range && !seen_base[letter_idx] && (len_base < CNT_W'(ALPHABET_LETTERS));
    wr_en      = cmd_i.load && fresh;
  end

  // mask and length update
  always_comb begin
    seen_d = seen_q;
    len_d  = len_q;
    if (cmd_i.clear) begin
      seen_d = '0;
      len_d  = '0;
    end else if (cmd_i.load) begin
      seen_d = seen_base;
      len_d  = len_base;
      if (fresh) begin
        seen_d[letter_idx] = 1'b1;
        len_d              = len_base + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
      len_q  <= '0;
    end else begin
      seen_q <= seen_d;
      len_q  <= len_d;
    end
  end

  // letter memory, appended at the current length
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[len_base[IDX_W-1:0]] <= cmd_i.letter;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign seen_o    = seen_q;
  assign len_o     = len_q;
  assign rd_data_o = rd_data_q;

endmodule

// ----- hw/rtl/ksc_rebuild.sv -----
// ----------------------------------------------------------------------------
// ksc_rebuild
// Map rebuild sequencer: writes both keyed alphabets into row memories, then
// walks the rows once and emits one forward/inverse map write per position.
// ----------------------------------------------------------------------------
module ksc_rebuild #(
  parameter int unsigned ALPHABET_LETTERS = ksc_pkg::KSC_ALPHABET
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  ksc_pkg::ksc_mode_e                     mode_i,
  input  logic [ksc_pkg::ROT_W-1:0]              rot_i,
  input  logic [ALPHABET_LETTERS-1:0]            seen1_i,
  input  logic [$clog2(ALPHABET_LETTERS+1)-1:0]  len1_i,
  input  logic [ALPHABET_LETTERS-1:0]            seen2_i,
  input  logic [$clog2(ALPHABET_LETTERS+1)-1:0]  len2_i,
  output logic [$clog2(ALPHABET_LETTERS)-1:0]    key_rd_addr_o,
  input  logic [ksc_pkg::LETTER_W-1:0]           key1_data_i,
  input  logic [ksc_pkg::LETTER_W-1:0]           key2_data_i,
  output ksc_pkg::ksc_map_wr_t                   map_wr_o,
  output logic                                   busy_o,
  output logic                                   done_o
);
  import ksc_pkg::*;

  localparam int unsigned IDX_W = $clog2(ALPHABET_LETTERS);
  localparam int unsigned CNT_W = $clog2(ALPHABET_LETTERS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ALPHABET_LETTERS - 1);
  localparam ksc_mod_tbl_t ROT_MOD = ksc_mod_table(ALPHABET_LETTERS);

  ksc_rb_state_e state_q, state_d;

  // alphabet generator
  logic                        sel_q, sel_d;
  logic [CNT_W-1:0]            a_q, a_d, c_q, c_d, pos_q, pos_d;
  logic                        slot_v_q, slot_v_d, slot_mem_q, slot_mem_d;
  logic [LETTER_W-1:0]         slot_c_q, slot_c_d;
  logic [CNT_W-1:0]            cur_len;
  logic [ALPHABET_LETTERS-1:0] cur_seen;
  logic                        from_mem, from_scan, gen_end;
  logic                        row_we;
  logic [LETTER_W-1:0]         row_wdata;

  // map pass
  logic [IDX_W-1:0]            i_q, i_d, j_q, j_d, mi_q;
  logic                        mv_q, mv_d;
  logic [LETTER_W-1:0]         row1_q [ALPHABET_LETTERS];
  logic [LETTER_W-1:0]         row2_q [ALPHABET_LETTERS];
  logic [LETTER_W-1:0]         r1a_q, r1b_q, r2_q;
  logic [LETTER_W-1:0]         pt, ct;

  // where the next keyed-alphabet letter comes from
  always_comb begin
    cur_len   = sel_q ? len2_i : len1_i;
    cur_seen  = sel_q ? seen2_i : seen1_i;
    from_mem  = a_q < cur_len;
    from_scan = !from_mem && (c_q < CNT_W'(ALPHABET_LETTERS));
    gen_end   = !from_mem && !from_scan;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      RB_IDLE:  if (start_i) state_d = RB_GEN;
      RB_GEN:   if (gen_end && sel_q) state_d = RB_MAP;
      RB_MAP:   if (i_q == LAST_IDX) state_d = RB_FLUSH;
      RB_FLUSH: state_d = RB_IDLE;
      default:  state_d = RB_IDLE;
    endcase
  end

  // counters and slot stage
  always_comb begin
    row_we     = slot_v_q;
    row_wdata  = slot_mem_q ? (sel_q ? key2_data_i : key1_data_i) : slot_c_q;
    sel_d      = sel_q;
    a_d        = a_q;
    c_d        = c_q;
    pos_d      = pos_q + CNT_W'(row_we);
    slot_v_d   = 1'b0;
    slot_mem_d = 1'b0;
    slot_c_d   = LETTER_W'(c_q);
    i_d        = i_q;
    j_d        = j_q;
    mv_d       = 1'b0;
    unique case (state_q)
      RB_IDLE: begin
        if (start_i) begin
          sel_d = 1'b0;
          a_d   = '0;
          c_d   = '0;
          pos_d = '0;
        end
      end
      RB_GEN: begin
        if (from_mem) begin
          slot_v_d   = 1'b1;
          slot_mem_d = 1'b1;
          a_d        = a_q + CNT_W'(1);
        end else if (from_scan) begin
          slot_v_d = !cur_seen[c_q[IDX_W-1:0]];
          c_d      = c_q + CNT_W'(1);
        end else if (!sel_q) begin
          sel_d = 1'b1;
          a_d   = '0;
          c_d   = '0;
          pos_d = '0;
        end else begin
          i_d = '0;
          j_d = ROT_MOD[rot_i][IDX_W-1:0];
        end
      end
      RB_MAP: begin
        mv_d = 1'b1;
        i_d  = i_q + IDX_W'(1);
        j_d  = (j_q == LAST_IDX) ? '0 : j_q + IDX_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= RB_IDLE;
      sel_q    <= 1'b0;
      a_q      <= '0;
      c_q      <= '0;
      pos_q    <= '0;
      slot_v_q <= 1'b0;
      i_q      <= '0;
      j_q      <= '0;
      mv_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      sel_q    <= sel_d;
      a_q      <= a_d;
      c_q      <= c_d;
      pos_q    <= pos_d;
      slot_v_q <= slot_v_d;
      i_q      <= i_d;
      j_q      <= j_d;
      mv_q     <= mv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_mem_q <= slot_mem_d;
    slot_c_q   <= slot_c_d;
    mi_q       <= i_q;
  end

  // keyed alphabet rows: one write per cycle, three registered reads
  always_ff @(posedge clk_i) begin
    if (row_we && !sel_q) begin
      row1_q[pos_q[IDX_W-1:0]] <= row_wdata;
    end
    if (row_we && sel_q) begin
      row2_q[pos_q[IDX_W-1:0]] <= row_wdata;
    end
    r1a_q <= row1_q[i_q];
    r1b_q <= row1_q[j_q];
    r2_q  <= row2_q[i_q];
  end

  // plaintext and ciphertext rows per keying mode
  always_comb begin
    unique case (mode_i)
      MODE_K1: begin
        pt = r1a_q;
        ct = LETTER_W'(mi_q);
      end
      MODE_K2: begin
        pt = LETTER_W'(mi_q);
        ct = r1a_q;
      end
      MODE_K3: begin
        pt = r1a_q;
        ct = r1b_q;
      end
      MODE_K4: begin
        pt = r1a_q;
        ct = r2_q;
      end
      default: begin
        pt = LETTER_W'(mi_q);
        ct = r1a_q;
      end
    endcase
    map_wr_o.en = mv_q;
    map_wr_o.pt = pt;
    map_wr_o.ct = ct;
  end

  assign key_rd_addr_o = a_q[IDX_W-1:0];
  assign busy_o        = (state_q != RB_IDLE);
  assign done_o        = (state_q == RB_FLUSH);

endmodule

// ----- hw/rtl/ksc_map_mem.sv -----
// ----------------------------------------------------------------------------
// ksc_map_mem
// Forward and inverse substitution maps, written together during a rebuild
// and read at one letter for text beats.
// ----------------------------------------------------------------------------
module ksc_map_mem #(
  parameter int unsigned ALPHABET_LETTERS = ksc_pkg::KSC_ALPHABET
) (
  input  logic                                clk_i,
  input  ksc_pkg::ksc_map_wr_t                wr_i,
  input  logic                                rd_en_i,
  input  logic [$clog2(ALPHABET_LETTERS)-1:0] rd_addr_i,
  output logic [ksc_pkg::LETTER_W-1:0]        fwd_o,
  output logic [ksc_pkg::LETTER_W-1:0]        inv_o
);
  import ksc_pkg::*;

  localparam int unsigned IDX_W = $clog2(ALPHABET_LETTERS);

  logic [LETTER_W-1:0] fwd_mem_q [ALPHABET_LETTERS];
  logic [LETTER_W-1:0] inv_mem_q [ALPHABET_LETTERS];
  logic [LETTER_W-1:0] fwd_q, inv_q;

  // both rows are permutations, so the inverse is written alongside
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      fwd_mem_q[wr_i.pt[IDX_W-1:0]] <= wr_i.ct;
      inv_mem_q[wr_i.ct[IDX_W-1:0]] <= wr_i.pt;
    end
    if (rd_en_i) begin
      fwd_q <= fwd_mem_q[rd_addr_i];
      inv_q <= inv_mem_q[rd_addr_i];
    end
  end

  assign fwd_o = fwd_q;
  assign inv_o = inv_q;

endmodule

// ----- hw/rtl/keyed_substitution_cipher.sv -----
// ----------------------------------------------------------------------------
// keyed_substitution_cipher
// Keyed monoalphabetic substitution with two keywords and four keying modes.
// ----------------------------------------------------------------------------
//   channel    dir   beat payload
//   cfg_chan   in    reg_index, wr_data          (register write)
//   req_chan   in    req_type, letter_in, restart_keyword, last_letter
//   res_chan   out   letter_out, last_out        (encipher/decipher only)
//
// Text beats with current maps run one per cycle while res_chan is not stalled,
// each one map memory read into the map read register, then the output register.
// A text beat after a keyword or register change waits for a map rebuild: its
// letter is read from the new maps in ST_ISSUE, then goes to the output register.
// Reset marks the maps for rebuild, so there is no clearing pass. A stalled
// result holds in the output register, with at most one text beat behind it.
// ----------------------------------------------------------------------------
`include "keyed_substitution_cipher_macros.svh"

module keyed_substitution_cipher #(
  parameter int unsigned ALPHABET_LETTERS = ksc_pkg::KSC_ALPHABET
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ksc_chan_if.sink    cfg_chan,
  ksc_chan_if.sink    req_chan,
  ksc_chan_if.source  res_chan
);
  import ksc_pkg::*;

  localparam int unsigned IDX_W = $clog2(ALPHABET_LETTERS);
  localparam int unsigned CNT_W = $clog2(ALPHABET_LETTERS + 1);

  ksc_state_e          state_q, state_d;
  ksc_mode_e           mode_q;
  logic [ROT_W-1:0]    rot_q;
  logic                stale_q, stale_d;
  logic [LETTER_W-1:0] pend_letter_q;
  logic                pend_dec_q, pend_last_q;
  logic                out_valid_q;
  ksc_res_t            out_data_q, out_data_d;

  ksc_req_t            req;
  ksc_cfg_t            cfg;
  ksc_req_e            req_code;
  logic                cfg_fire, in_fire, is_text, out_free, out_load, pend_in_range;

  ksc_key_cmd_t                key1_cmd, key2_cmd;
  logic [ALPHABET_LETTERS-1:0] seen1, seen2;
  logic [CNT_W-1:0]            len1, len2;
  logic [IDX_W-1:0]            key_rd_addr;
  logic [LETTER_W-1:0]         key1_data, key2_data;
  ksc_map_wr_t                 map_wr;
  logic                        rb_start, rb_busy, rb_done;
  logic                        map_rd_en;
  logic [IDX_W-1:0]            map_rd_addr;
  logic [LETTER_W-1:0]         map_fwd, map_inv;

  // handshakes
  assign req      = req_chan.data;
  assign cfg      = cfg_chan.data;
  assign req_code = ksc_req_e'(req.req_type);
  assign out_free = !out_valid_q || res_chan.ready;
  assign cfg_chan.ready = 1'b1;
  assign req_chan.ready = (state_q == ST_IDLE) || ((state_q == ST_LOOKUP) && out_free);
  assign cfg_fire = cfg_chan.valid && cfg_chan.ready;
  assign in_fire  = req_chan.valid && req_chan.ready;
  assign is_text  = in_fire && ((req_code == REQ_ENCIPHER) || (req_code == REQ_DECIPHER));
  assign out_load = (state_q == ST_LOOKUP) && out_free;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (is_text) state_d = stale_q ? ST_REBUILD : ST_LOOKUP;
      end
      ST_LOOKUP: begin
        if (is_text) begin
          state_d = stale_q ? ST_REBUILD : ST_LOOKUP;
        end else if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_REBUILD: if (rb_done) state_d = ST_ISSUE;
      ST_ISSUE:   state_d = ST_LOOKUP;
      default:    state_d = ST_IDLE;
    endcase
  end

  // keyword commands, rebuild start and map read
  always_comb begin
    key1_cmd.load    = in_fire && (req_code == REQ_KEY1);
    key1_cmd.restart = req.restart_keyword;
    key1_cmd.clear   = in_fire && (req_code == REQ_CLEAR);
    key1_cmd.letter  = req.letter_in;
    key2_cmd.load    = in_fire && (req_code == REQ_KEY2);
    key2_cmd.restart = req.restart_keyword;
    key2_cmd.clear   = in_fire && (req_code == REQ_CLEAR);
    key2_cmd.letter  = req.letter_in;
    rb_start         = is_text && stale_q;
    map_rd_en        = (is_text && !stale_q) || (state_q == ST_ISSUE);
    map_rd_addr      = (state_q == ST_ISSUE) ? pend_letter_q[IDX_W-1:0]
                                             : req.letter_in[IDX_W-1:0];
  end

  // maps go stale on any keyword load or clear, or a write to the mode or rotation register
  always_comb begin
    stale_d = stale_q;
    if (rb_done) begin
      stale_d = 1'b0;
    end
    if (key1_cmd.load || key2_cmd.load || key1_cmd.clear) begin
      stale_d = 1'b1;
    end
    if (cfg_fire && ((cfg.reg_index == CFG_KEYING_MODE) ||
                     (cfg.reg_index == CFG_ROW_ROTATION))) begin
      stale_d = 1'b1;
    end
  end

  // result from the map read, letters beyond the alphabet pass unchanged
  always_comb begin
    pend_in_range = (LETTER_W+1)'(pend_letter_q) < (LETTER_W+1)'(ALPHABET_LETTERS);
    out_data_d.letter_out = pend_in_range ? (pend_dec_q ? map_inv : map_fwd)
                                          : pend_letter_q;
    out_data_d.last_out   = pend_last_q;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_K2;
      rot_q  <= '0;
    end else if (cfg_fire) begin
      unique case (cfg.reg_index)
        CFG_KEYING_MODE:  mode_q <= ksc_mode_e'(cfg.wr_data[1:0]);
        CFG_ROW_ROTATION: rot_q  <= cfg.wr_data[ROT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      stale_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      stale_q <= stale_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (res_chan.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // pending text beat and output register
  always_ff @(posedge clk_i) begin
    if (is_text) begin
      pend_letter_q <= req.letter_in;
      pend_dec_q    <= (req_code == REQ_DECIPHER);
      pend_last_q   <= req.last_letter;
    end
    if (out_load) begin
      out_data_q <= out_data_d;
    end
  end

  assign res_chan.valid = out_valid_q;
  assign res_chan.data  = out_data_q;

  ksc_key_store #(
    .ALPHABET_LETTERS (ALPHABET_LETTERS)
  ) u_key1 (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (key1_cmd),
    .rd_addr_i (key_rd_addr),
    .seen_o    (seen1),
    .len_o     (len1),
    .rd_data_o (key1_data)
  );

  ksc_key_store #(
    .ALPHABET_LETTERS (ALPHABET_LETTERS)
  ) u_key2 (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (key2_cmd),
    .rd_addr_i (key_rd_addr),
    .seen_o    (seen2),
    .len_o     (len2),
    .rd_data_o (key2_data)
  );

  ksc_rebuild #(
    .ALPHABET_LETTERS (ALPHABET_LETTERS)
  ) u_rebuild (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (rb_start),
    .mode_i        (mode_q),
    .rot_i         (rot_q),
    .seen1_i       (seen1),
    .len1_i        (len1),
    .seen2_i       (seen2),
    .len2_i        (len2),
    .key_rd_addr_o (key_rd_addr),
    .key1_data_i   (key1_data),
    .key2_data_i   (key2_data),
    .map_wr_o      (map_wr),
    .busy_o        (rb_busy),
    .done_o        (rb_done)
  );

  ksc_map_mem #(
    .ALPHABET_LETTERS (ALPHABET_LETTERS)
  ) u_map_mem (
    .clk_i     (clk_i),
    .wr_i      (map_wr),
    .rd_en_i   (map_rd_en),
    .rd_addr_i (map_rd_addr),
    .fwd_o     (map_fwd),
    .inv_o     (map_inv)
  );

  // checks
  `KSC_ASSERT_NOW(a_no_beat_in_rebuild, rb_busy, !in_fire, "beat taken in rebuild")
  `KSC_ASSERT_NOW(a_fresh_maps_on_load, out_load, !stale_q, "result from stale maps")
  `KSC_ASSERT_NOW(a_map_wr_in_rebuild, map_wr.en, state_q == ST_REBUILD, "stray map write")
  `KSC_ASSERT_NEXT(a_issue_after_done, rb_done, state_q == ST_ISSUE, "no issue after rebuild")

endmodule

// ----- dv/keyed_substitution_cipher_checker.sv -----
// ----------------------------------------------------------------------------
// keyed_substitution_cipher_checker
// Watches the register, request and result channels, keeps its own copy of
// the keywords and substitution maps, and compares every result beat with
// the letter it predicts, in order.
// ----------------------------------------------------------------------------
module keyed_substitution_cipher_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  ksc_pkg::ksc_cfg_t cfg_data_i,
  input  logic              req_valid_i,
  input  logic              req_ready_i,
  input  ksc_pkg::ksc_req_t req_data_i,
  input  logic              res_valid_i,
  input  logic              res_ready_i,
  input  ksc_pkg::ksc_res_t res_data_i,
  output int unsigned       mismatches_o,
  output int unsigned       letters_due_o
);
  import ksc_pkg::*;

  localparam int unsigned ABC = KSC_ALPHABET;

  typedef logic [LETTER_W-1:0] letter_t;

  // register copies
  logic [1:0]       mode_q;
  logic [ROT_W-1:0] rot_q;

  // keyword stores, index 0 for keyword one and 1 for keyword two
  letter_t          key_letters [2][ABC];
  logic [ABC-1:0]   key_seen    [2];
  int unsigned      key_len     [2];
  letter_t          keyed_row   [2][ABC];

  // substitution maps
  letter_t          fwd_map [ABC];
  letter_t          inv_map [ABC];
  bit               maps_stale;

  ksc_res_t         letters_due_q [$];
  int unsigned      mismatch_cnt;

  function automatic void key_empty(int k);
    key_seen[k] = '0;
    key_len[k]  = 0;
  endfunction

  // repeats and out-of-range letters are dropped, length stops at the alphabet
  function automatic void key_append(int k, letter_t l);
    if (l < ABC && !key_seen[k][l] && key_len[k] < ABC) begin
      key_seen[k][l]             = 1'b1;
      key_letters[k][key_len[k]] = l;
      key_len[k]++;
    end
  endfunction

  // keyword letters first, then the unused ones in ascending order
  function automatic void form_row(int k);
    logic [ABC-1:0] used;
    int unsigned    n;
    letter_t        c;
    used = '0;
    n    = 0;
    for (int i = 0; i < int'(key_len[k]); i++) begin
      c = key_letters[k][i];
      if (c < ABC && !used[c]) begin
        used[c]      = 1'b1;
        keyed_row[k][n] = c;
        n++;
      end
    end
    for (int i = 0; i < ABC; i++) begin
      if (!used[i]) begin
        keyed_row[k][n] = letter_t'(i);
        n++;
      end
    end
  endfunction

  // lay the plaintext row over the ciphertext row for the keying mode
  function automatic void derive_maps();
    int unsigned shift;
    letter_t     pt;
    letter_t     ct;
    form_row(0);
    form_row(1);
    shift = int'(rot_q) % ABC;
    for (int i = 0; i < ABC; i++) begin
      pt = letter_t'(i);
      ct = letter_t'(i);
      case (mode_q)
        MODE_K1: begin
          pt = keyed_row[0][i];
        end
        MODE_K3: begin
          pt = keyed_row[0][i];
          ct = keyed_row[0][(i + shift) % ABC];
        end
        MODE_K4: begin
          pt = keyed_row[0][i];
          ct = keyed_row[1][i];
        end
        default: begin
          ct = keyed_row[0][i];
        end
      endcase
      fwd_map[pt] = ct;
    end
    for (int i = 0; i < ABC; i++) begin
      inv_map[fwd_map[i]] = letter_t'(i);
    end
    maps_stale = 1'b0;
  endfunction

  // one text beat through the forward or inverse map
  function automatic ksc_res_t substitute(ksc_req_t b);
    ksc_res_t r;
    if (maps_stale) begin
      derive_maps();
    end
    r.last_out = b.last_letter;
    if (b.letter_in < ABC) begin
      r.letter_out = (b.req_type == REQ_DECIPHER) ? inv_map[b.letter_in]
                                                  : fwd_map[b.letter_in];
    end else begin
      r.letter_out = b.letter_in;
    end
    return r;
  endfunction

  function automatic void take_request(ksc_req_t b);
    case (b.req_type)
      REQ_KEY1: begin
        if (b.restart_keyword) key_empty(0);
        key_append(0, b.letter_in);
        maps_stale = 1'b1;
      end
      REQ_KEY2: begin
        if (b.restart_keyword) key_empty(1);
        key_append(1, b.letter_in);
        maps_stale = 1'b1;
      end
      REQ_ENCIPHER, REQ_DECIPHER: begin
        letters_due_q.push_back(substitute(b));
      end
      REQ_CLEAR: begin
        key_empty(0);
        key_empty(1);
        maps_stale = 1'b1;
      end
      default: begin
      end
    endcase
  endfunction

  // results are checked before the request of the same edge is taken
  always @(posedge clk_i or negedge rst_ni) begin : watch
    ksc_res_t want;
    if (!rst_ni) begin
      mode_q     = MODE_K2;
      rot_q      = '0;
      key_empty(0);
      key_empty(1);
      for (int i = 0; i < ABC; i++) begin
        fwd_map[i] = letter_t'(i);
        inv_map[i] = letter_t'(i);
      end
      maps_stale   = 1'b0;
      letters_due_q.delete();
      mismatch_cnt = 0;
      mismatches_o  <= 0;
      letters_due_o <= 0;
    end else begin
      if (res_valid_i && res_ready_i) begin
        if (letters_due_q.size() == 0) begin
          $display("%0t: result beat with no letter due: letter %0d last %0b",
                   $time, res_data_i.letter_out, res_data_i.last_out);
          mismatch_cnt++;
        end else begin
          want = letters_due_q.pop_front();
          if (res_data_i.letter_out !== want.letter_out) begin
            $display("%0t: letter_out expected %0d actual %0d",
                     $time, want.letter_out, res_data_i.letter_out);
            mismatch_cnt++;
          end
          if (res_data_i.last_out !== want.last_out) begin
            $display("%0t: last_out expected %0b actual %0b",
                     $time, want.last_out, res_data_i.last_out);
            mismatch_cnt++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_data_i.reg_index)
          CFG_KEYING_MODE: begin
            mode_q     = cfg_data_i.wr_data[1:0];
            maps_stale = 1'b1;
          end
          CFG_ROW_ROTATION: begin
            rot_q      = cfg_data_i.wr_data[ROT_W-1:0];
            maps_stale = 1'b1;
          end
          default: begin
          end
        endcase
      end
      if (req_valid_i && req_ready_i) begin
        take_request(req_data_i);
      end
      mismatches_o  <= mismatch_cnt;
      letters_due_o <= letters_due_q.size();
    end
  end

endmodule

// ----- dv/keyed_substitution_cipher_tb.sv -----
// ----------------------------------------------------------------------------
// keyed_substitution_cipher_tb
// Drives keyword, text and clear beats and register writes into the cipher
// under random idling on both sides, and gives the verdict from the checker.
// ----------------------------------------------------------------------------
module keyed_substitution_cipher_tb;
  import ksc_pkg::*;

  localparam int unsigned ITEM_TARGET     = 2000;
  localparam int unsigned NUM_PHASES      = 10;
  localparam int unsigned PHASE_ITEMS     = ITEM_TARGET / NUM_PHASES;
  // worst map rebuild is two full keywords plus three passes of the alphabet
  localparam int unsigned SETTLE_CYCLES   = 5 * KSC_ALPHABET + 40;
  localparam int unsigned HOLD_OFF_CYCLES = 600;
  localparam int unsigned LIMIT_CYCLES    = 2_000_000;
  localparam int unsigned LETTER_MAX      = (1 << LETTER_W) - 1;

  // request codes the block ignores
  localparam logic [2:0] REQ_SPARE_LO = 3'd5;
  localparam logic [2:0] REQ_SPARE_HI = 3'd7;
  // register indexes beyond the list
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  typedef logic [LETTER_W-1:0] letter_t;

  logic        clk_i;
  logic        rst_ni;
  int unsigned mismatches;
  int unsigned letters_due;
  int unsigned cycle_cnt = 0;
  int unsigned items_sent = 0;
  bit          tx_idle_on = 1'b0;
  bit          rx_idle_on = 1'b0;
  bit          hold_off_go = 1'b0;

  ksc_chan_if #(.payload_t(ksc_cfg_t)) cfg_chan ();
  ksc_chan_if #(.payload_t(ksc_req_t)) req_chan ();
  ksc_chan_if #(.payload_t(ksc_res_t)) res_chan ();

  keyed_substitution_cipher u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_chan (cfg_chan),
    .req_chan (req_chan),
    .res_chan (res_chan)
  );

  keyed_substitution_cipher_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_chan.valid),
    .cfg_ready_i   (cfg_chan.ready),
    .cfg_data_i    (cfg_chan.data),
    .req_valid_i   (req_chan.valid),
    .req_ready_i   (req_chan.ready),
    .req_data_i    (req_chan.data),
    .res_valid_i   (res_chan.valid),
    .res_ready_i   (res_chan.ready),
    .res_data_i    (res_chan.data),
    .mismatches_o  (mismatches),
    .letters_due_o (letters_due)
  );

  // clock
  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side: random stalls and one long hold-off
  initial begin
    res_chan.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_go) begin
        res_chan.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        hold_off_go = 1'b0;
        res_chan.ready <= 1'b1;
      end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
        res_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        res_chan.ready <= 1'b1;
      end else begin
        res_chan.ready <= 1'b1;
      end
    end
  end

  // one request beat, with an optional idle burst ahead of it
  task automatic send_beat(logic [2:0] kind, letter_t l, bit restart, bit last);
    ksc_req_t b;
    b.req_type        = kind;
    b.letter_in       = l;
    b.restart_keyword = restart;
    b.last_letter     = last;
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      req_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    req_chan.valid <= 1'b1;
    req_chan.data  <= b;
    do @(posedge clk_i); while (!req_chan.ready);
    if (kind <= REQ_CLEAR) items_sent++;
  endtask

  function automatic letter_t pick_letter();
    if ($urandom_range(0, 19) == 0) return letter_t'($urandom_range(KSC_ALPHABET, LETTER_MAX));
    return letter_t'($urandom_range(0, KSC_ALPHABET - 1));
  endfunction

  // a keyword, now and then a full permutation of the alphabet
  task automatic load_keyword(bit second);
    letter_t     perm [KSC_ALPHABET];
    letter_t     tmp;
    logic [2:0]  kind;
    int unsigned n;
    int unsigned j;
    kind = second ? REQ_KEY2 : REQ_KEY1;
    if ($urandom_range(0, 15) == 0) begin
      for (int i = 0; i < KSC_ALPHABET; i++) perm[i] = letter_t'(i);
      for (int i = KSC_ALPHABET - 1; i > 0; i--) begin
        j       = $urandom_range(0, i);
        tmp     = perm[i];
        perm[i] = perm[j];
        perm[j] = tmp;
      end
      for (int i = 0; i < KSC_ALPHABET; i++) begin
        send_beat(kind, perm[i], i == 0, 1'($urandom_range(0, 1)));
      end
      send_beat(kind, pick_letter(), 1'b0, 1'($urandom_range(0, 1)));
    end else begin
      n = $urandom_range(1, 8);
      for (int i = 0; i < int'(n); i++) begin
        send_beat(kind, pick_letter(),
                  (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 19) == 0),
                  1'($urandom_range(0, 1)));
      end
    end
  endtask

  // a message of text letters, end marked on the final one
  task automatic send_text();
    logic [2:0]  kind;
    int unsigned n;
    bit          mixed;
    n     = $urandom_range(1, 16);
    kind  = $urandom_range(0, 1) ? REQ_ENCIPHER : REQ_DECIPHER;
    mixed = ($urandom_range(0, 9) == 0);
    for (int i = 0; i < int'(n); i++) begin
      if (mixed) kind = $urandom_range(0, 1) ? REQ_ENCIPHER : REQ_DECIPHER;
      send_beat(kind, pick_letter(), 1'($urandom_range(0, 1)), i == int'(n) - 1);
    end
  endtask

  // mostly keyword loads followed by text, some clears and noise
  task automatic send_message();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      send_beat(3'($urandom_range(0, 7)), letter_t'($urandom_range(0, LETTER_MAX)),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end else if (pick < 12) begin
      send_beat(REQ_CLEAR, letter_t'($urandom_range(0, LETTER_MAX)),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      send_text();
    end else begin
      if ($urandom_range(0, 9) < 4) load_keyword(1'b0);
      if ($urandom_range(0, 9) < 3) load_keyword(1'b1);
      send_text();
    end
  endtask

  // wait for every due letter, then for any rebuild still running
  task automatic settle();
    req_chan.valid <= 1'b0;
    do @(posedge clk_i); while (letters_due != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // register beats back to back, valid stays high between them
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    ksc_cfg_t w;
    w.reg_index = idx;
    w.wr_data   = d;
    cfg_chan.valid <= 1'b1;
    cfg_chan.data  <= w;
    do @(posedge clk_i); while (!cfg_chan.ready);
  endtask

  task automatic set_config(logic [1:0] mode, logic [ROT_W-1:0] rot);
    cfg_write(CFG_KEYING_MODE, {3'($urandom_range(0, 7)), mode});
    cfg_write(CFG_ROW_ROTATION, rot);
    if ($urandom_range(0, 1)) begin
      cfg_write($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
                CFG_DATA_W'($urandom_range(0, LETTER_MAX)));
    end
    cfg_chan.valid <= 1'b0;
  endtask

  // stimulus and verdict
  initial begin
    logic [1:0]       phase_mode [NUM_PHASES];
    logic [ROT_W-1:0] phase_rot  [NUM_PHASES];
    int unsigned      phase_end;
    phase_mode = '{MODE_K1, MODE_K2, MODE_K3, MODE_K3, MODE_K3,
                   MODE_K4, MODE_K1, MODE_K4, MODE_K2, MODE_K3};
    phase_rot  = '{5'd0, 5'd25, 5'd0, 5'd25, 5'd26, 5'd31, 5'd31, 5'd0, 5'd7, 5'd13};
    rst_ni = 1'b0;
    cfg_chan.valid <= 1'b0;
    cfg_chan.data  <= '0;
    req_chan.valid <= 1'b0;
    req_chan.data  <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: identity after reset, keyword corner cases, ignored codes
    rx_idle_on = 1'b1;
    send_beat(REQ_ENCIPHER, 5'd0, 1'b0, 1'b0);
    send_beat(REQ_ENCIPHER, 5'd25, 1'b0, 1'b1);
    send_beat(REQ_ENCIPHER, 5'd31, 1'b1, 1'b1);
    send_beat(REQ_DECIPHER, 5'd26, 1'b0, 1'b0);
    send_beat(REQ_KEY1, 5'd31, 1'b1, 1'b0);
    send_beat(REQ_KEY1, 5'd25, 1'b0, 1'b0);
    send_beat(REQ_KEY1, 5'd25, 1'b0, 1'b1);
    send_beat(REQ_KEY1, 5'd0, 1'b0, 1'b0);
    send_beat(REQ_KEY1, 5'd27, 1'b0, 1'b0);
    send_beat(REQ_KEY2, 5'd16, 1'b1, 1'b0);
    send_beat(REQ_KEY2, 5'd0, 1'b0, 1'b0);
    send_beat(REQ_ENCIPHER, 5'd0, 1'b0, 1'b0);
    send_beat(REQ_DECIPHER, 5'd25, 1'b0, 1'b1);
    send_beat(REQ_SPARE_LO, 5'd3, 1'b1, 1'b1);
    send_beat(REQ_SPARE_HI, 5'd31, 1'b0, 1'b1);
    send_beat(REQ_CLEAR, 5'd9, 1'b0, 1'b0);
    send_beat(REQ_ENCIPHER, 5'd12, 1'b0, 1'b1);
    send_beat(REQ_KEY2, 5'd28, 1'b1, 1'b0);
    send_beat(REQ_DECIPHER, 5'd31, 1'b0, 1'b1);
    settle();

    // random phases, one register setting each
    for (int p = 0; p < NUM_PHASES; p++) begin
      tx_idle_on = (p != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      rx_idle_on = (p != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      if (p == 8) begin
        phase_mode[p] = 2'($urandom_range(0, 3));
        phase_rot[p]  = ROT_W'($urandom_range(0, LETTER_MAX));
      end
      set_config(phase_mode[p], phase_rot[p]);
      if (p == 1) begin
        tx_idle_on  = 1'b0;
        hold_off_go = 1'b1;
      end
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) send_message();
      settle();
    end

    if (mismatches == 0 && letters_due == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/ksc_pkg.sv
hw/rtl/ksc_chan_if.sv
hw/rtl/ksc_key_store.sv
hw/rtl/ksc_rebuild.sv
hw/rtl/ksc_map_mem.sv
hw/rtl/keyed_substitution_cipher.sv
dv/keyed_substitution_cipher_checker.sv
dv/keyed_substitution_cipher_tb.sv
